// File: design/lcar_pkg.sv
// Shared constants, codes and handshake types for the load cell reader.
package lcar_pkg;

	localparam int RING_DEPTH  = 16;
	localparam int SAMPLE_BITS = 24;

	localparam int TIMEOUT_W  = 24;
	localparam int TARE_CNT_W = 4;
	localparam int CMD_W      = 2;
	localparam int NET_W      = SAMPLE_BITS + 1;
	localparam int HEAD_W     = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int BIDX_W     = $clog2(SAMPLE_BITS + 1);
	localparam int SUM_W      = SAMPLE_BITS + $clog2(RING_DEPTH);
	localparam int TARE_W     = SAMPLE_BITS + TARE_CNT_W;
	localparam int DIV_W      = (SUM_W > TARE_W) ? SUM_W : TARE_W;
	localparam int DVS_W      = (FILL_W > TARE_CNT_W) ? FILL_W : TARE_CNT_W;

	localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = TIMEOUT_W'(200000);
	localparam logic [TARE_CNT_W-1:0] ATTEMPTS_RST = TARE_CNT_W'(8);

	// command codes carried with each tick
	localparam logic [CMD_W-1:0] CMD_PLAIN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TARE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// APB register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_TIMEOUT  = 1'b0;
	localparam logic [PADDR_W-3:0] REG_ATTEMPTS = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic latch;     // capture the accepted item
		logic step;      // advance the wire protocol by one tick
		logic div_start; // load the divider
		logic div_tare;  // divider operands: tare accumulator, else ring sum
		logic mean_wr;   // store quotient as filtered mean
		logic tare_wr;   // store quotient as tare reference
		logic out_load;  // load the result register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_mean;
		logic need_tare;
		logic div_done;
	} ctrl_sts_t;

endpackage

// File: design/lcar_div.sv
// Signed by unsigned restoring divider, one quotient bit per cycle.
module lcar_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [lcar_pkg::DIV_W-1:0]      dividend,
	input  logic        [lcar_pkg::DVS_W-1:0]      divisor,
	output logic                                   done,
	output logic signed [lcar_pkg::SAMPLE_BITS-1:0] quotient
);
	import lcar_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] mag_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DIV_W-1:0] mag_in;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DIV_W-1:0] signed_q;

	assign mag_in = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
	assign trial  = {rem_q, mag_q[DIV_W-1]};
	assign diff   = trial - {1'b0, dvs_q};
	assign ge     = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[DIV_W-1];
		end else if (run_q) begin
			mag_q <= {mag_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	// truncation toward zero: divide magnitudes, restore sign
	assign signed_q = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quotient = signed_q[SAMPLE_BITS-1:0];
	assign done     = done_q;

endmodule

// File: design/lcar_datapath.sv
// Wire protocol, sample ring, tare accounting and result register.
module lcar_datapath (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic        [lcar_pkg::CMD_W-1:0]          in_cmd,
	input  logic                                       in_data_pin,
	input  logic        [lcar_pkg::TIMEOUT_W-1:0]      timeout,
	input  logic        [lcar_pkg::TARE_CNT_W-1:0]     attempts,
	input  lcar_pkg::ctrl_cmd_t                        ctl,
	output lcar_pkg::ctrl_sts_t                        sts,
	output logic                                       clock_pin,
	output logic                                       sample_done,
	output logic                                       timed_out,
	output logic signed [lcar_pkg::SAMPLE_BITS-1:0]    raw_value,
	output logic signed [lcar_pkg::SAMPLE_BITS-1:0]    filtered_value,
	output logic signed [lcar_pkg::NET_W-1:0]          net_value,
	output logic                                       tare_valid,
	output logic                                       tare_failed
);
	import lcar_pkg::*;

	localparam logic [2:0] PH_WAIT      = 3'd0;
	localparam logic [2:0] PH_BIT_HIGH  = 3'd1;
	localparam logic [2:0] PH_BIT_LOW   = 3'd2;
	localparam logic [2:0] PH_TAIL_HIGH = 3'd3;
	localparam logic [2:0] PH_TAIL_LOW  = 3'd4;

	localparam logic [BIDX_W-1:0] BIT_LAST  = BIDX_W'(SAMPLE_BITS - 1);
	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

	// captured item
	logic [CMD_W-1:0] cmd_q;
	logic             din_q;

	// protocol state
	logic [2:0]             phase_q, phase_n;
	logic [BIDX_W-1:0]      bidx_q, bidx_n;
	logic [SAMPLE_BITS-1:0] shift_q, shift_n;
	logic [TIMEOUT_W-1:0]   wait_q, wait_n;

	// filter state
	logic signed [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic [HEAD_W-1:0]             head_q;
	logic [FILL_W-1:0]             fill_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] raw_q, mean_q;

	// tare state
	logic signed [SAMPLE_BITS-1:0] ref_q, ref_n;
	logic                          held_q, held_n;
	logic                          busy_q, busy_n;
	logic [TARE_CNT_W-1:0]         tries_q, tries_n;
	logic [TARE_CNT_W-1:0]         good_q, good_n;
	logic signed [TARE_W-1:0]      acc_q, acc_n;

	// per-tick flags
	logic clk_q, clk_n;
	logic done_q, done_n;
	logic tmo_q, tmo_n;
	logic fail_q, fail_n;
	logic need_tare_q, need_tare_n;

	logic                          attempt_end;
	logic [TARE_CNT_W-1:0]         need;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic signed [SAMPLE_BITS-1:0] old_entry;

	logic signed [DIV_W-1:0]       div_dividend;
	logic        [DVS_W-1:0]       div_divisor;
	logic                          div_done;
	logic signed [SAMPLE_BITS-1:0] div_quot;

	assign sample    = shift_q;
	assign old_entry = (fill_q == FILL_FULL) ? rd_q : '0;
	assign need      = (attempts == '0) ? TARE_CNT_W'(1) : attempts;

	always_comb begin
		phase_n     = phase_q;
		bidx_n      = bidx_q;
		shift_n     = shift_q;
		wait_n      = wait_q;
		ref_n       = ref_q;
		held_n      = held_q;
		busy_n      = busy_q;
		tries_n     = tries_q;
		good_n      = good_q;
		acc_n       = acc_q;
		clk_n       = 1'b0;
		done_n      = 1'b0;
		tmo_n       = 1'b0;
		fail_n      = 1'b0;
		need_tare_n = 1'b0;
		attempt_end = 1'b0;

		// command acts first
		unique case (cmd_q)
			CMD_TARE: begin
				if (!busy_q) begin
					busy_n  = 1'b1;
					tries_n = '0;
					good_n  = '0;
					acc_n   = '0;
				end
			end
			CMD_CLEAR: begin
				held_n  = 1'b0;
				ref_n   = '0;
				busy_n  = 1'b0;
				tries_n = '0;
				good_n  = '0;
				acc_n   = '0;
			end
			default: begin
			end
		endcase

		unique case (phase_q)
			PH_WAIT: begin
				if (!din_q) begin
					wait_n  = '0;
					bidx_n  = '0;
					shift_n = '0;
					phase_n = PH_BIT_HIGH;
				end else if (wait_q >= timeout) begin
					wait_n      = '0;
					tmo_n       = 1'b1;
					attempt_end = 1'b1;
				end else begin
					wait_n = wait_q + 1'b1;
				end
			end
			PH_BIT_HIGH: begin
				clk_n   = 1'b1;
				phase_n = PH_BIT_LOW;
			end
			PH_BIT_LOW: begin
				shift_n = {shift_q[SAMPLE_BITS-2:0], din_q};
				bidx_n  = bidx_q + 1'b1;
				phase_n = (bidx_q == BIT_LAST) ? PH_TAIL_HIGH : PH_BIT_HIGH;
			end
			PH_TAIL_HIGH: begin
				clk_n   = 1'b1;
				phase_n = PH_TAIL_LOW;
			end
			default: begin
				done_n      = 1'b1;
				attempt_end = 1'b1;
				bidx_n      = '0;
				wait_n      = '0;
				phase_n     = PH_WAIT;
			end
		endcase

		// tare accounting at the end of a read attempt
		if (attempt_end && busy_n) begin
			if (done_n) begin
				acc_n  = acc_n + TARE_W'(sample);
				good_n = good_n + 1'b1;
			end
			tries_n = tries_n + 1'b1;
			if (tries_n >= need) begin
				busy_n = 1'b0;
				if (good_n == '0) begin
					fail_n = 1'b1;
				end else begin
					need_tare_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			bidx_q      <= '0;
			shift_q     <= '0;
			wait_q      <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			raw_q       <= '0;
			mean_q      <= '0;
			ref_q       <= '0;
			held_q      <= 1'b0;
			busy_q      <= 1'b0;
			tries_q     <= '0;
			good_q      <= '0;
			acc_q       <= '0;
			clk_q       <= 1'b0;
			done_q      <= 1'b0;
			tmo_q       <= 1'b0;
			fail_q      <= 1'b0;
			need_tare_q <= 1'b0;
		end else begin
			if (ctl.step) begin
				phase_q     <= phase_n;
				bidx_q      <= bidx_n;
				shift_q     <= shift_n;
				wait_q      <= wait_n;
				ref_q       <= ref_n;
				held_q      <= held_n;
				busy_q      <= busy_n;
				tries_q     <= tries_n;
				good_q      <= good_n;
				acc_q       <= acc_n;
				clk_q       <= clk_n;
				done_q      <= done_n;
				tmo_q       <= tmo_n;
				fail_q      <= fail_n;
				need_tare_q <= need_tare_n;
				if (done_n) begin
					raw_q  <= sample;
					sum_q  <= sum_q - SUM_W'(old_entry) + SUM_W'(sample);
					head_q <= (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
					if (fill_q != FILL_FULL) begin
						fill_q <= fill_q + 1'b1;
					end
				end
			end
			if (ctl.mean_wr) begin
				mean_q <= div_quot;
			end
			if (ctl.tare_wr) begin
				ref_q  <= div_quot;
				held_q <= 1'b1;
			end
		end
	end

	// ring storage: one write port, registered read at the head
	always_ff @(posedge clk) begin
		if (ctl.step && done_n) begin
			ring_mem[head_q] <= sample;
		end
		rd_q <= ring_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= in_cmd;
			din_q <= in_data_pin;
		end
	end

	assign div_dividend = ctl.div_tare ? DIV_W'(acc_q) : DIV_W'(sum_q);
	assign div_divisor  = ctl.div_tare ? DVS_W'(good_q) : DVS_W'(fill_q);

	lcar_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign sts.need_mean = done_q;
	assign sts.need_tare = need_tare_q;
	assign sts.div_done  = div_done;

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			clock_pin      <= clk_q;
			sample_done    <= done_q;
			timed_out      <= tmo_q;
			raw_value      <= raw_q;
			filtered_value <= mean_q;
			net_value      <= held_q ? (NET_W'(raw_q) - NET_W'(ref_q)) : NET_W'(raw_q);
			tare_valid     <= held_q;
			tare_failed    <= fail_q;
		end
	end

endmodule

// File: design/lcar_ctrl.sv
// Sequencer: tick step, mean divide, tare divide, result hand-off.
module lcar_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lcar_pkg::ctrl_sts_t sts,
	output lcar_pkg::ctrl_cmd_t ctl
);
	import lcar_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_STEP      = 3'd1;
	localparam logic [2:0] S_MEAN_GO   = 3'd2;
	localparam logic [2:0] S_MEAN_WAIT = 3'd3;
	localparam logic [2:0] S_TARE_GO   = 3'd4;
	localparam logic [2:0] S_TARE_WAIT = 3'd5;
	localparam logic [2:0] S_PUSH      = 3'd6;

	logic [2:0] state_q, state_n;
	logic       ovalid_q;
	logic       room;

	assign room = !ovalid_q || out_ready;

	always_comb begin
		state_n  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_n   = S_STEP;
				end
			end
			S_STEP: begin
				ctl.step = 1'b1;
				state_n  = S_MEAN_GO;
			end
			S_MEAN_GO: begin
				if (sts.need_mean) begin
					ctl.div_start = 1'b1;
					state_n       = S_MEAN_WAIT;
				end else begin
					state_n = S_TARE_GO;
				end
			end
			S_MEAN_WAIT: begin
				if (sts.div_done) begin
					ctl.mean_wr = 1'b1;
					state_n     = S_TARE_GO;
				end
			end
			S_TARE_GO: begin
				ctl.div_tare = 1'b1;
				if (sts.need_tare) begin
					ctl.div_start = 1'b1;
					state_n       = S_TARE_WAIT;
				end else begin
					state_n = S_PUSH;
				end
			end
			S_TARE_WAIT: begin
				if (sts.div_done) begin
					ctl.tare_wr = 1'b1;
					state_n     = S_PUSH;
				end
			end
			S_PUSH: begin
				if (room) begin
					ctl.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;

endmodule

// File: design/load_cell_adc_reader_filter_core.sv
// Top level of the load cell converter reader with moving average and tare.
//
// Each input item is one bit-clock tick of a two-wire load cell converter: the sampled
// data line level plus a command (plain tick, start tare, clear tare); each tick yields
// exactly one result item. While waiting, clock_pin stays low until the data line is
// seen low or ready_timeout_ticks high ticks have passed (the next high tick reports
// timed_out). A read is a pulse per data bit, one tick high and one tick low each, bits
// taken MSB first on the low tick, then a 25th pulse; on the low tick of that pulse the
// word appears on raw_value as a signed value with sample_done set, is pushed into a
// 16-entry ring that starts empty, and filtered_value becomes the mean of the filled
// entries, truncated toward zero. A tare averages the good samples of the next
// tare_attempts read attempts (zero counts as one); tare_failed marks a tare that
// ended without any good sample, and net_value is raw_value minus the tare reference
// while tare_valid is set. An ordinary tick goes from acceptance to the result register
// through capture, protocol step, two decision states and hand-off; the hand-off waits
// while an earlier result is still untaken. A tick that completes a conversion adds one
// pass through the shared restoring divider, which retires one quotient bit per cycle
// over the 28-bit ring sum. A tick on which a tare ends with at least one good sample
// adds a divider pass over the tare accumulator. One tick is in flight at a time; a new
// item is taken while the previous result still waits in the output register.
// Registers (APB, 32-bit data): 0x0 ready_timeout_ticks [23:0], 0x4 tare_attempts [3:0].
module load_cell_adc_reader_filter_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// APB configuration port
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic        [lcar_pkg::PADDR_W-1:0]     paddr,
	input  logic        [lcar_pkg::PDATA_W-1:0]     pwdata,
	output logic        [lcar_pkg::PDATA_W-1:0]     prdata,
	output logic                                    pready,
	// tick items in
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic        [lcar_pkg::CMD_W-1:0]       cmd,
	input  logic                                    data_pin,
	// result items out
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    clock_pin,
	output logic                                    sample_done,
	output logic                                    timed_out,
	output logic signed [lcar_pkg::SAMPLE_BITS-1:0] raw_value,
	output logic signed [lcar_pkg::SAMPLE_BITS-1:0] filtered_value,
	output logic signed [lcar_pkg::NET_W-1:0]       net_value,
	output logic                                    tare_valid,
	output logic                                    tare_failed
);
	import lcar_pkg::*;

	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [TARE_CNT_W-1:0] attempts_q;
	logic [PADDR_W-3:0]    reg_idx;
	logic                  cfg_wr;

	ctrl_cmd_t ctl;
	ctrl_sts_t sts;

	// register index is the word address; byte lanes are ignored
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			attempts_q <= ATTEMPTS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TIMEOUT:  timeout_q  <= pwdata[TIMEOUT_W-1:0];
				REG_ATTEMPTS: attempts_q <= pwdata[TARE_CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TIMEOUT:  prdata = PDATA_W'(timeout_q);
			REG_ATTEMPTS: prdata = PDATA_W'(attempts_q);
			default:      prdata = '0;
		endcase
	end

	// sequencer
	lcar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// protocol, ring filter, tare and result register
	lcar_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_cmd         (cmd),
		.in_data_pin    (data_pin),
		.timeout        (timeout_q),
		.attempts       (attempts_q),
		.ctl            (ctl),
		.sts            (sts),
		.clock_pin      (clock_pin),
		.sample_done    (sample_done),
		.timed_out      (timed_out),
		.raw_value      (raw_value),
		.filtered_value (filtered_value),
		.net_value      (net_value),
		.tare_valid     (tare_valid),
		.tare_failed    (tare_failed)
	);

endmodule

// File: design/lcar_checker.sv
// Port-level checks for the load cell reader, bound to the top level.
module lcar_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic                                    clock_pin,
	input logic                                    sample_done,
	input logic                                    timed_out,
	input logic signed [lcar_pkg::SAMPLE_BITS-1:0] raw_value,
	input logic signed [lcar_pkg::NET_W-1:0]       net_value,
	input logic                                    tare_valid,
	input logic                                    tare_failed
);
	import lcar_pkg::*;

	// a pending result item is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped before acceptance");

	// a conversion and a timeout cannot end the same tick
	a_done_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(sample_done && timed_out))
		else $error("sample_done and timed_out together");

	// a tare can only fail on an attempt that timed out
	a_fail_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tare_failed |-> timed_out)
		else $error("tare_failed without timeout");

	// the finishing tick of a conversion drives the clock low
	a_done_clk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_done |-> !clock_pin)
		else $error("clock high on conversion tick");

	// without a tare the net value is the raw value
	a_net_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tare_valid |-> net_value == NET_W'(raw_value))
		else $error("net differs from raw without tare");

endmodule

bind load_cell_adc_reader_filter_core lcar_checker u_lcar_checker (.*);

// File: tb/load_cell_tick_checker.sv
// Checker for the load cell reader: mirrors wire protocol, ring filter and tare, compares results.
module load_cell_tick_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic                                    pready,
	input  logic        [lcar_pkg::PADDR_W-1:0]     paddr,
	input  logic        [lcar_pkg::PDATA_W-1:0]     pwdata,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic        [lcar_pkg::CMD_W-1:0]       cmd,
	input  logic                                    data_pin,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic                                    clock_pin,
	input  logic                                    sample_done,
	input  logic                                    timed_out,
	input  logic signed [lcar_pkg::SAMPLE_BITS-1:0] raw_value,
	input  logic signed [lcar_pkg::SAMPLE_BITS-1:0] filtered_value,
	input  logic signed [lcar_pkg::NET_W-1:0]       net_value,
	input  logic                                    tare_valid,
	input  logic                                    tare_failed,
	output int                                      fail_count,
	output int                                      due_count,
	output int                                      tick_count,
	output int                                      sample_count,
	output int                                      timeout_count,
	output int                                      tare_set_count,
	output int                                      tare_fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import lcar_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef enum logic [2:0] {
		RD_WAIT,
		RD_BIT_HI,
		RD_BIT_LO,
		RD_TAIL_HI,
		RD_TAIL_LO
	} rd_phase_t;

	typedef struct packed {
		logic                   clk_level;
		logic                   done;
		logic                   tmo;
		logic [SAMPLE_BITS-1:0] raw;
		logic [SAMPLE_BITS-1:0] mean;
		logic [NET_W-1:0]       net;
		logic                   tare_on;
		logic                   tare_fail;
	} tick_result_t;

	// register copies
	logic [TIMEOUT_W-1:0]  cfg_timeout;
	logic [TARE_CNT_W-1:0] cfg_attempts;

	// reader state
	rd_phase_t                     rd_phase;
	logic [BIDX_W-1:0]             bit_count;
	logic [SAMPLE_BITS-1:0]        shift_word;
	logic [TIMEOUT_W-1:0]          wait_count;
	logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
	logic [HEAD_W-1:0]             ring_head;
	logic [FILL_W-1:0]             ring_fill;
	logic signed [SUM_W-1:0]       ring_sum;
	logic signed [SAMPLE_BITS-1:0] last_raw;
	logic signed [SAMPLE_BITS-1:0] last_mean;
	logic signed [SAMPLE_BITS-1:0] tare_ref;
	logic                          tare_held;
	logic                          tare_busy;
	logic [TARE_CNT_W-1:0]         tare_tries;
	logic [TARE_CNT_W-1:0]         tare_good;
	logic signed [TARE_W-1:0]      tare_accum;

	tick_result_t results_due [$];
	int           mismatch_count;

	initial begin
		cfg_timeout  = TIMEOUT_RST;
		cfg_attempts = ATTEMPTS_RST;
		rd_phase     = RD_WAIT;
		bit_count    = '0;
		shift_word   = '0;
		wait_count   = '0;
		for (int i = 0; i < RING_DEPTH; i++)
			ring[i] = '0;
		ring_head  = '0;
		ring_fill  = '0;
		ring_sum   = '0;
		last_raw   = '0;
		last_mean  = '0;
		tare_ref   = '0;
		tare_held  = 1'b0;
		tare_busy  = 1'b0;
		tare_tries = '0;
		tare_good  = '0;
		tare_accum = '0;
		mismatch_count  = 0;
		fail_count      = 0;
		due_count       = 0;
		tick_count      = 0;
		sample_count    = 0;
		timeout_count   = 0;
		tare_set_count  = 0;
		tare_fail_count = 0;
	end

	// close one read attempt; returns 1 when a tare ends with no good sample
	function automatic logic close_attempt(input logic good);
		logic [TARE_CNT_W-1:0] need;
		if (!tare_busy)
			return 1'b0;
		if (good) begin
			tare_accum = tare_accum + last_raw;
			tare_good  = tare_good + 1'b1;
		end
		tare_tries = tare_tries + 1'b1;
		need = (cfg_attempts == '0) ? TARE_CNT_W'(1) : cfg_attempts;
		if (tare_tries < need)
			return 1'b0;
		tare_busy = 1'b0;
		if (tare_good == '0)
			return 1'b1;
		tare_ref  = SAMPLE_BITS'(longint'(tare_accum) / longint'(tare_good));
		tare_held = 1'b1;
		tare_set_count++;
		return 1'b0;
	endfunction

	function automatic void push_sample(input logic signed [SAMPLE_BITS-1:0] s);
		ring_sum        = ring_sum - ring[ring_head] + s;
		ring[ring_head] = s;
		ring_head       = (ring_head == HEAD_W'(RING_DEPTH - 1)) ? '0 : ring_head + 1'b1;
		if (ring_fill < FILL_W'(RING_DEPTH))
			ring_fill = ring_fill + 1'b1;
		last_mean = SAMPLE_BITS'(longint'(ring_sum) / longint'(ring_fill));
	endfunction

	// advance the mirror by one tick and return what the block must report
	function automatic tick_result_t next_tick_result(input logic [CMD_W-1:0] c, input logic din);
		tick_result_t r;
		r = '0;
		if (c == CMD_TARE) begin
			if (!tare_busy) begin
				tare_busy  = 1'b1;
				tare_tries = '0;
				tare_good  = '0;
				tare_accum = '0;
			end
		end else if (c == CMD_CLEAR) begin
			tare_held  = 1'b0;
			tare_ref   = '0;
			tare_busy  = 1'b0;
			tare_tries = '0;
			tare_good  = '0;
			tare_accum = '0;
		end
		case (rd_phase)
			RD_WAIT: begin
				if (!din) begin
					wait_count = '0;
					bit_count  = '0;
					shift_word = '0;
					rd_phase   = RD_BIT_HI;
				end else if (wait_count >= cfg_timeout) begin
					wait_count  = '0;
					r.tmo       = 1'b1;
					r.tare_fail = close_attempt(1'b0);
				end else begin
					wait_count = wait_count + 1'b1;
				end
			end
			RD_BIT_HI: begin
				r.clk_level = 1'b1;
				rd_phase    = RD_BIT_LO;
			end
			RD_BIT_LO: begin
				shift_word = {shift_word[SAMPLE_BITS-2:0], din};
				bit_count  = bit_count + 1'b1;
				rd_phase   = (bit_count >= BIDX_W'(SAMPLE_BITS)) ? RD_TAIL_HI : RD_BIT_HI;
			end
			RD_TAIL_HI: begin
				r.clk_level = 1'b1;
				rd_phase    = RD_TAIL_LO;
			end
			default: begin
				last_raw = shift_word;
				push_sample(last_raw);
				r.done      = 1'b1;
				r.tare_fail = close_attempt(1'b1);
				bit_count   = '0;
				wait_count  = '0;
				rd_phase    = RD_WAIT;
			end
		endcase
		r.raw  = last_raw;
		r.mean = last_mean;
		if (tare_held)
			r.net = $signed({last_raw[SAMPLE_BITS-1], last_raw})
				- $signed({tare_ref[SAMPLE_BITS-1], tare_ref});
		else
			r.net = {last_raw[SAMPLE_BITS-1], last_raw};
		r.tare_on = tare_held;
		return r;
	endfunction

	always @(posedge clk) begin
		tick_result_t got;
		tick_result_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_TIMEOUT:  cfg_timeout  = pwdata[TIMEOUT_W-1:0];
					REG_ATTEMPTS: cfg_attempts = pwdata[TARE_CNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.clk_level = clock_pin;
				got.done      = sample_done;
				got.tmo       = timed_out;
				got.raw       = raw_value;
				got.mean      = filtered_value;
				got.net       = net_value;
				got.tare_on   = tare_valid;
				got.tare_fail = tare_failed;
				if (results_due.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%t: result item with nothing due", $realtime);
				end else begin
					want = results_due.pop_front();
					if (want.done)
						sample_count++;
					if (want.tmo)
						timeout_count++;
					if (want.tare_fail)
						tare_fail_count++;
					if (got.clk_level !== want.clk_level || got.done !== want.done
						|| got.tmo !== want.tmo || got.raw !== want.raw
						|| got.mean !== want.mean || got.net !== want.net
						|| got.tare_on !== want.tare_on || got.tare_fail !== want.tare_fail) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX) begin
							$display("%t: mismatch, exp clk=%0b done=%0b tmo=%0b raw=%0d mean=%0d net=%0d tv=%0b tf=%0b",
								$realtime, want.clk_level, want.done, want.tmo, $signed(want.raw),
								$signed(want.mean), $signed(want.net), want.tare_on, want.tare_fail);
							$display("%t:           got clk=%0b done=%0b tmo=%0b raw=%0d mean=%0d net=%0d tv=%0b tf=%0b",
								$realtime, got.clk_level, got.done, got.tmo, $signed(got.raw),
								$signed(got.mean), $signed(got.net), got.tare_on, got.tare_fail);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				results_due.push_back(next_tick_result(cmd, data_pin));
				tick_count++;
			end
			due_count <= results_due.size();
		end
	end

endmodule

// File: tb/tb.sv
// Top of the load cell reader regression: clock, reset, stimulus, register writes and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lcar_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 11;
	localparam int LIMIT_CYCLES    = 1_500_000;
	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 176;
	localparam int LONG_HOLD       = 300;
	// worst tick: protocol step plus two divider passes, with margin
	localparam int SETTLE_CYCLES   = 80;
	// one full read is 48 bit ticks and 2 tail ticks; this many high ticks
	// always brings the reader back to waiting
	localparam int REALIGN_TICKS   = 51;

	// unused command code, acts as a plain tick
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [PADDR_W-1:0]            paddr     = '0;
	logic [PDATA_W-1:0]            pwdata    = '0;
	logic [PDATA_W-1:0]            prdata;
	logic                          pready;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic [CMD_W-1:0]              cmd       = CMD_PLAIN;
	logic                          data_pin  = 1'b1;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          clock_pin;
	logic                          sample_done;
	logic                          timed_out;
	logic signed [SAMPLE_BITS-1:0] raw_value;
	logic signed [SAMPLE_BITS-1:0] filtered_value;
	logic signed [NET_W-1:0]       net_value;
	logic                          tare_valid;
	logic                          tare_failed;

	int fail_count;
	int due_count;
	int tick_count;
	int sample_count;
	int timeout_count;
	int tare_set_count;
	int tare_fail_count;

	// idle mix: percent of cycles the sender sits out, percent the receiver stalls
	int send_idle_pct = 0;
	int stall_pct     = 0;
	// long receiver hold-off: bumping hold_tag starts one, counted in the receiver
	int hold_tag  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int          items_sent  = 0;
	int          cycle_count = 0;
	logic [23:0] cur_timeout = TIMEOUT_RST;

	always #(CLK_HALF) clk = ~clk;

	load_cell_adc_reader_filter_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.data_pin       (data_pin),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.clock_pin      (clock_pin),
		.sample_done    (sample_done),
		.timed_out      (timed_out),
		.raw_value      (raw_value),
		.filtered_value (filtered_value),
		.net_value      (net_value),
		.tare_valid     (tare_valid),
		.tare_failed    (tare_failed)
	);

	load_cell_tick_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.data_pin        (data_pin),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.clock_pin       (clock_pin),
		.sample_done     (sample_done),
		.timed_out       (timed_out),
		.raw_value       (raw_value),
		.filtered_value  (filtered_value),
		.net_value       (net_value),
		.tare_valid      (tare_valid),
		.tare_failed     (tare_failed),
		.fail_count      (fail_count),
		.due_count       (due_count),
		.tick_count      (tick_count),
		.sample_count    (sample_count),
		.timeout_count   (timeout_count),
		.tare_set_count  (tare_set_count),
		.tare_fail_count (tare_fail_count)
	);

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, due_count);
			$display("load_cell_adc_reader_filter_core regression: fail");
			$finish;
		end
	end

	// receiver: random stalls per the current mix, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_tag != hold_seen) begin
			hold_seen <= hold_tag;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// mostly plain ticks, now and then a tare, a clear or the spare code
	function automatic logic [CMD_W-1:0] pick_cmd();
		int r;
		r = $urandom_range(999);
		if (r < 15)
			return CMD_TARE;
		else if (r < 18)
			return CMD_CLEAR;
		else if (r < 28)
			return CMD_SPARE;
		return CMD_PLAIN;
	endfunction

	// one tick item; called at a rising edge, returns at the edge that accepted it.
	// valid stays high into the next call unless that call idles first.
	task automatic send_tick(input logic [CMD_W-1:0] c, input logic din);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		data_pin <= din;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// stop offering, wait for every due result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// APB write: setup, access held until pready, then back to idle
	task automatic write_reg(input logic [PADDR_W-3:0] idx, input logic [PDATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// well-formed conversion: high ticks while waiting, the ready low, a pulse per bit
	// with the word on the low ticks, then the 25th pulse
	task automatic run_read(input logic [SAMPLE_BITS-1:0] word, input int wait_hi);
		repeat (wait_hi)
			send_tick(pick_cmd(), 1'b1);
		send_tick(pick_cmd(), 1'b0);
		for (int i = SAMPLE_BITS - 1; i >= 0; i--) begin
			send_tick(pick_cmd(), 1'($urandom_range(1)));
			send_tick(pick_cmd(), word[i]);
		end
		send_tick(pick_cmd(), 1'($urandom_range(1)));
		send_tick(pick_cmd(), 1'($urandom_range(1)));
	endtask

	task automatic realign();
		repeat (REALIGN_TICKS)
			send_tick(pick_cmd(), 1'b1);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_word();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'hFFFFFF;
			3: return 24'h000000;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// high ticks before ready: usually few, sometimes past the timeout when it is small
	function automatic int pick_wait();
		int cap;
		cap = (cur_timeout > 10) ? 12 : int'(cur_timeout) + 2;
		if ($urandom_range(99) < 70)
			return $urandom_range(2);
		return $urandom_range(cap);
	endfunction

	logic [PDATA_W-1:0] phase_timeout  [N_PHASES];
	logic [PDATA_W-1:0] phase_attempts [N_PHASES];

	initial begin
		int  r;
		int  k;
		int  phase_start;
		bit  held_once;
		bit  paused_once;

		// reset values first, then the extremes and a few in between
		phase_timeout  = '{200000, 4, 0, 24'hFFFFFF, 1, 9, 2, 0};
		phase_attempts = '{8, 3, 0, 15, 1, 2, 4, 15};
		held_once   = 1'b0;
		paused_once = 1'b0;

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: timeouts racing tare commands on the same tick
		write_reg(REG_TIMEOUT, 1);
		write_reg(REG_ATTEMPTS, 2);
		cur_timeout = 1;
		send_tick(CMD_PLAIN, 1'b1);  // wait count goes to one
		send_tick(CMD_TARE, 1'b1);   // tare starts and the same tick times out: first try
		send_tick(CMD_TARE, 1'b1);   // tare while busy, ignored
		send_tick(CMD_SPARE, 1'b1);  // spare code; second timeout ends the tare with no sample
		send_tick(CMD_TARE, 1'b1);   // fresh tare
		send_tick(CMD_CLEAR, 1'b1);  // clear aborts it; the timeout then counts for nothing
		send_tick(CMD_CLEAR, 1'b1);  // clear with nothing held
		drain();
		// zero timeout and zero attempts: every high tick times out, one try per tare
		write_reg(REG_TIMEOUT, 0);
		write_reg(REG_ATTEMPTS, 0);
		cur_timeout = 0;
		send_tick(CMD_TARE, 1'b1);   // tare fails on its very first tick
		send_tick(CMD_PLAIN, 1'b1);
		send_tick(CMD_SPARE, 1'b1);

		// random phases, each under its own register setting and idle mix
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			write_reg(REG_TIMEOUT, phase_timeout[ph]);
			write_reg(REG_ATTEMPTS, phase_attempts[ph]);
			cur_timeout = phase_timeout[ph][23:0];
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct <= 0;  end
				1: begin send_idle_pct = 72; stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  stall_pct <= 72; end
				default: begin send_idle_pct = 20; stall_pct <= 20; end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				// output held off while ticks keep coming: the block must back up
				if (ph == 0 && !held_once && items_sent - phase_start > 60) begin
					hold_tag <= hold_tag + 1;
					held_once = 1'b1;
				end
				// sender pause until everything has come out
				if (ph == 1 && !paused_once && items_sent - phase_start > 80) begin
					drain();
					paused_once = 1'b1;
				end
				r = $urandom_range(99);
				if (r < 80) begin
					run_read(pick_word(), pick_wait());
				end else if (r < 90) begin
					// read cut short partway through the bits
					send_tick(pick_cmd(), 1'b0);
					k = $urandom_range(1, 46);
					repeat (k)
						send_tick(pick_cmd(), 1'($urandom_range(1)));
					realign();
				end else begin
					// pure noise, any command code
					k = $urandom_range(1, 12);
					repeat (k)
						send_tick(CMD_W'($urandom_range(3)), 1'($urandom_range(1)));
					realign();
				end
			end
		end

		drain();
		$display("covered %0d ticks: %0d conversions, %0d timeouts, %0d tares set, %0d tares failed",
			tick_count, sample_count, timeout_count, tare_set_count, tare_fail_count);
		$display("over %0d register settings, four idle mixes, a long output hold and a full pause",
			N_PHASES + 2);
		if (fail_count == 0) begin
			$display("load_cell_adc_reader_filter_core regression: pass");
		end else begin
			$display("%0d failures", fail_count);
			$display("load_cell_adc_reader_filter_core regression: fail");
		end
		$finish;
	end

endmodule

// File: load_cell_adc_reader_filter_core.f
design/lcar_pkg.sv
design/lcar_div.sv
design/lcar_datapath.sv
design/lcar_ctrl.sv
design/load_cell_adc_reader_filter_core.sv
design/lcar_checker.sv
tb/load_cell_tick_checker.sv
tb/tb.sv
